[sv/sdmm_pkg.sv]
// Shared constants, codes and inter-module types of the sparse-dense multiply core.
package sdmm_pkg;

	// Matrix geometry and number format
	localparam int MAX_INNER    = 64;
	localparam int MAX_OUT_COLS = 16;
	localparam int FRAC_BITS    = 8;

	localparam int VAL_W   = 16;
	localparam int ROW_W   = 16;
	localparam int INNER_W = $clog2(MAX_INNER);     // dense row / cur_inner bits
	localparam int COL_W   = $clog2(MAX_OUT_COLS);  // result column bits
	localparam int ADDR_W  = INNER_W + COL_W;
	localparam int DEPTH   = MAX_INNER * MAX_OUT_COLS;
	localparam int DVD_W   = 17;                    // cur_inner + index_step, no wrap
	localparam int DSR_W   = 7;                     // inner size register width
	localparam int CNT_W   = $clog2(DVD_W + 1);
	localparam int PROD_W  = 2 * VAL_W;

	// Stream and configuration widths
	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 40;
	localparam int CFG_A_W  = 1;
	localparam int CFG_D_W  = 7;

	// Register indexes
	localparam logic [CFG_A_W-1:0] REG_INNER_SIZE = 1'b0;
	localparam logic [CFG_A_W-1:0] REG_OUT_COLS   = 1'b1;

	// Item kinds carried on tuser
	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_SPARSE = 1'b1;

	// Divider result
	typedef struct packed {
		logic               done;
		logic [DVD_W-1:0]   quo;
		logic [INNER_W-1:0] rem;
	} div_res_t;

	// One column operand pair entering the multiplier
	typedef struct packed {
		logic                    vld;
		logic [COL_W-1:0]        col;
		logic                    last;
		logic signed [VAL_W-1:0] a;
		logic signed [VAL_W-1:0] b;
	} mac_req_t;

	// Scaled product leaving the multiplier
	typedef struct packed {
		logic             vld;
		logic [COL_W-1:0] col;
		logic             last;
		logic [VAL_W-1:0] term;
	} mac_res_t;

endpackage

[sv/sdmm_div.sv]
// Restoring divider, one quotient bit per cycle: position sum over inner size.
module sdmm_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sdmm_pkg::DVD_W-1:0]  dividend,
	input  logic [sdmm_pkg::DSR_W-1:0]  divisor,
	output sdmm_pkg::div_res_t          res
);

	logic                        busy_q;
	logic                        done_q;
	logic [sdmm_pkg::CNT_W-1:0]  cnt_q;
	logic [sdmm_pkg::DVD_W-1:0]  dvd_q;
	logic [sdmm_pkg::DSR_W-1:0]  dsr_q;
	logic [sdmm_pkg::DSR_W-1:0]  rem_q;
	logic [sdmm_pkg::DSR_W-1:0]  trial;
	logic                        ge;

	// Shift in the next dividend bit; remainder stays below the divisor (<= 64)
	assign trial = {rem_q[sdmm_pkg::DSR_W-2:0], dvd_q[sdmm_pkg::DVD_W-1]};
	assign ge    = (trial >= dsr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= sdmm_pkg::CNT_W'(sdmm_pkg::DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == sdmm_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? (trial - dsr_q) : trial;
			dvd_q <= {dvd_q[sdmm_pkg::DVD_W-2:0], ge};
		end
	end

	assign res.done = done_q;
	assign res.quo  = dvd_q;
	assign res.rem  = rem_q[sdmm_pkg::INNER_W-1:0];

endmodule

[sv/sdmm_mac.sv]
// Shared fixed-point multiplier: registered product, arithmetic shift, 16-bit wrap.
module sdmm_mac (
	input  logic                clk,
	input  logic                arst_n,
	input  sdmm_pkg::mac_req_t  req,
	output sdmm_pkg::mac_res_t  res
);

	logic                              vld_s2;
	logic                              last_s2;
	logic [sdmm_pkg::COL_W-1:0]        col_s2;
	logic signed [sdmm_pkg::PROD_W-1:0] prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= req.vld;
		end
	end

	// Exact 32-bit product, operands tagged with their column
	always_ff @(posedge clk) begin
		last_s2 <= req.last;
		col_s2  <= req.col;
		prod_s2 <= req.a * req.b;
	end

	// floor(p / 2^FRAC_BITS) keeps bits FRAC_BITS and up; low 16 bits survive
	assign res.vld  = vld_s2;
	assign res.col  = col_s2;
	assign res.last = last_s2;
	assign res.term = prod_s2[sdmm_pkg::FRAC_BITS +: sdmm_pkg::VAL_W];

endmodule

[sv/sparse_dense_matrix_multiply_core.sv]
// Top level: sequencer, dense store, row accumulators and output register.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------------
//  in      | s_tvalid / s_tready   | s_tdata, s_tuser = action, s_tlast = last_entry
//  out     | m_tvalid / m_tready   | m_tdata, m_tlast = last_of_run
//  config  | cfg_we                | cfg_addr, cfg_data
//
// A load beat is written straight into the dense store. A sparse beat runs through the
// bit-serial divider and then makes one pass per column through the shared multiplier;
// each emitted row adds one output beat per column.
// The output register lets a result wait while the sequencer keeps working up to the
// next emit; a stall on m_tready holds the emit loop. After reset the row is closed and
// inner_size/out_cols are 64/16; the dense store holds garbage until loaded.
module sparse_dense_matrix_multiply_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_we,
	input  logic [sdmm_pkg::CFG_A_W-1:0]    cfg_addr,
	input  logic [sdmm_pkg::CFG_D_W-1:0]    cfg_data,
	// input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// value[15:0], load_row[21:16], load_col[25:22], index_step[41:26], zero fill
	input  logic [sdmm_pkg::S_DATA_W-1:0]   s_tdata,
	input  logic                            s_tuser,   // action
	input  logic                            s_tlast,   // last_entry
	// output stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// out_row[15:0], out_col[19:16], out_value[35:20], zero fill
	output logic [sdmm_pkg::M_DATA_W-1:0]   m_tdata,
	output logic                            m_tlast    // last_of_run
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_EMIT,
		S_ADV,
		S_MAC
	} state_t;

	state_t state_q;

	// Saturated configuration
	logic [sdmm_pkg::DSR_W-1:0]   inner_eff_q;
	logic [sdmm_pkg::COL_W-1:0]   cols_m1_q;

	// Running position and row state
	logic [sdmm_pkg::ROW_W-1:0]   cur_row_q;
	logic [sdmm_pkg::INNER_W-1:0] cur_inner_q;
	logic                         row_open_q;
	logic [sdmm_pkg::VAL_W-1:0]   row_accum_q [sdmm_pkg::MAX_OUT_COLS];

	// Per-item registers
	logic signed [sdmm_pkg::VAL_W-1:0] value_q;
	logic                         last_q;
	logic [sdmm_pkg::DVD_W-1:0]   adv_q;
	logic [sdmm_pkg::INNER_W-1:0] k_q;
	logic                         fresh_q;
	logic                         emit_final_q;
	logic [sdmm_pkg::COL_W-1:0]   em_j_q;
	logic                         iss_on_q;
	logic [sdmm_pkg::COL_W-1:0]   iss_j_q;

	// Output register
	logic                         m_tvalid_q;
	logic                         m_tlast_q;
	logic [sdmm_pkg::ROW_W-1:0]   o_row_q;
	logic [sdmm_pkg::COL_W-1:0]   o_col_q;
	logic [sdmm_pkg::VAL_W-1:0]   o_val_q;

	// Dense store read stage
	logic                         rd_v_s1;
	logic                         rd_last_s1;
	logic [sdmm_pkg::COL_W-1:0]   rd_j_s1;
	logic [sdmm_pkg::VAL_W-1:0]   rd_data_s1;
	logic [sdmm_pkg::VAL_W-1:0]   dense_mem [sdmm_pkg::DEPTH];

	// Input field unpacking
	logic [sdmm_pkg::VAL_W-1:0]   in_value;
	logic [sdmm_pkg::INNER_W-1:0] in_load_row;
	logic [sdmm_pkg::COL_W-1:0]   in_load_col;
	logic [15:0]                  in_step;
	logic                         s_fire;
	logic                         out_free;
	logic                         mem_we;
	logic                         mem_re;

	logic                         div_start;
	logic [sdmm_pkg::DVD_W-1:0]   div_dvd;
	sdmm_pkg::div_res_t           div_res;
	sdmm_pkg::mac_req_t           mac_req;
	sdmm_pkg::mac_res_t           mac_res;

	assign in_value    = s_tdata[15:0];
	assign in_load_row = s_tdata[21:16];
	assign in_load_col = s_tdata[25:22];
	assign in_step     = s_tdata[41:26];

	assign s_tready = (state_q == S_IDLE);
	assign s_fire   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign mem_we = s_fire && (s_tuser == sdmm_pkg::ACT_LOAD);
	assign mem_re = (state_q == S_MAC) && iss_on_q;

	// Divider for the row advance and inner position of each sparse entry
	assign div_start = s_fire && (s_tuser == sdmm_pkg::ACT_SPARSE);
	assign div_dvd   = sdmm_pkg::DVD_W'(cur_inner_q) + sdmm_pkg::DVD_W'(in_step);

	sdmm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (inner_eff_q),
		.res      (div_res)
	);

	// Multiplier fed from the dense store read stage
	assign mac_req.vld  = rd_v_s1;
	assign mac_req.col  = rd_j_s1;
	assign mac_req.last = rd_last_s1;
	assign mac_req.a    = value_q;
	assign mac_req.b    = rd_data_s1;

	sdmm_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.res    (mac_res)
	);

	// Dense store: one write port for loads, one registered read for the column sweep
	always_ff @(posedge clk) begin
		if (mem_we) begin
			dense_mem[{in_load_row, in_load_col}] <= in_value;
		end
		if (mem_re) begin
			rd_data_s1 <= dense_mem[{k_q, iss_j_q}];
		end
		rd_j_s1    <= iss_j_q;
		rd_last_s1 <= (iss_j_q == cols_m1_q);
	end

	// Sequencer, row state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			inner_eff_q  <= sdmm_pkg::DSR_W'(sdmm_pkg::MAX_INNER);
			cols_m1_q    <= sdmm_pkg::COL_W'(sdmm_pkg::MAX_OUT_COLS - 1);
			cur_row_q    <= '0;
			cur_inner_q  <= '0;
			row_open_q   <= 1'b0;
			for (int i = 0; i < sdmm_pkg::MAX_OUT_COLS; i++) begin
				row_accum_q[i] <= '0;
			end
			value_q      <= '0;
			last_q       <= 1'b0;
			adv_q        <= '0;
			k_q          <= '0;
			fresh_q      <= 1'b0;
			emit_final_q <= 1'b0;
			em_j_q       <= '0;
			iss_on_q     <= 1'b0;
			iss_j_q      <= '0;
			rd_v_s1      <= 1'b0;
			m_tvalid_q   <= 1'b0;
			m_tlast_q    <= 1'b0;
			o_row_q      <= '0;
			o_col_q      <= '0;
			o_val_q      <= '0;
		end else begin
			// configuration, saturated on write
			if (cfg_we) begin
				unique case (cfg_addr)
					sdmm_pkg::REG_INNER_SIZE: begin
						if (cfg_data == '0) begin
							inner_eff_q <= sdmm_pkg::DSR_W'(1);
						end else if (cfg_data > sdmm_pkg::CFG_D_W'(sdmm_pkg::MAX_INNER)) begin
							inner_eff_q <= sdmm_pkg::DSR_W'(sdmm_pkg::MAX_INNER);
						end else begin
							inner_eff_q <= cfg_data[sdmm_pkg::DSR_W-1:0];
						end
					end
					sdmm_pkg::REG_OUT_COLS: begin
						if (cfg_data[4:0] == '0) begin
							cols_m1_q <= '0;
						end else if (cfg_data[4:0] > 5'(sdmm_pkg::MAX_OUT_COLS)) begin
							cols_m1_q <= sdmm_pkg::COL_W'(sdmm_pkg::MAX_OUT_COLS - 1);
						end else begin
							cols_m1_q <= sdmm_pkg::COL_W'(cfg_data[4:0] - 5'd1);
						end
					end
					default: begin
					end
				endcase
			end

			// output beat taken; in S_EMIT the emit loop refills the register
			if (m_tready && (state_q != S_EMIT)) begin
				m_tvalid_q <= 1'b0;
			end

			rd_v_s1 <= mem_re;

			unique case (state_q)
				S_IDLE: begin
					if (div_start) begin
						value_q <= in_value;
						last_q  <= s_tlast;
						state_q <= S_DIV;
					end
				end

				S_DIV: begin
					if (div_res.done) begin
						adv_q   <= div_res.quo;
						k_q     <= div_res.rem;
						fresh_q <= (div_res.quo != '0) || !row_open_q;
						if ((div_res.quo != '0) && row_open_q) begin
							emit_final_q <= 1'b0;
							em_j_q       <= '0;
							state_q      <= S_EMIT;
						end else begin
							state_q <= S_ADV;
						end
					end
				end

				// step the position, clear a fresh row, start the column sweep
				S_ADV: begin
					cur_row_q   <= cur_row_q + adv_q[sdmm_pkg::ROW_W-1:0];
					cur_inner_q <= k_q;
					if (fresh_q) begin
						for (int i = 0; i < sdmm_pkg::MAX_OUT_COLS; i++) begin
							row_accum_q[i] <= '0;
						end
					end
					iss_on_q <= 1'b1;
					iss_j_q  <= '0;
					state_q  <= S_MAC;
				end

				S_MAC: begin
					if (iss_on_q) begin
						if (iss_j_q == cols_m1_q) begin
							iss_on_q <= 1'b0;
						end else begin
							iss_j_q <= iss_j_q + 1'b1;
						end
					end
					if (mac_res.vld) begin
						row_accum_q[mac_res.col] <= row_accum_q[mac_res.col] + mac_res.term;
						if (mac_res.last) begin
							row_open_q <= 1'b1;
							if (last_q) begin
								emit_final_q <= 1'b1;
								em_j_q       <= '0;
								state_q      <= S_EMIT;
							end else begin
								state_q <= S_IDLE;
							end
						end
					end
				end

				// one result beat per column when the output register is free
				S_EMIT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tlast_q  <= (em_j_q == cols_m1_q);
						o_row_q    <= cur_row_q;
						o_col_q    <= em_j_q;
						o_val_q    <= row_accum_q[em_j_q];
						if (em_j_q == cols_m1_q) begin
							if (emit_final_q) begin
								cur_row_q   <= '0;
								cur_inner_q <= '0;
								row_open_q  <= 1'b0;
								state_q     <= S_IDLE;
							end else begin
								state_q <= S_ADV;
							end
						end else begin
							em_j_q <= em_j_q + 1'b1;
						end
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = m_tlast_q;
	assign m_tdata  = {4'b0, o_val_q, o_col_q, o_row_q};

endmodule
